// ===== rtl/core/ilbr_pkg.sv =====
// Shared types, constants and helpers for the index-linked block ring.
`default_nettype none

package ilbr_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_MOVE  = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef logic [IDX_W-1:0] blk_idx_t;

    typedef struct packed {
        logic       mode;
        logic [3:0] block_number;
    } cmd_t;

    typedef struct packed {
        logic [3:0] result_block;
        logic       status;
    } rsp_t;

    typedef struct packed {
        logic     en;
        blk_idx_t addr;
    } link_rd_t;

    typedef struct packed {
        logic     en;
        blk_idx_t addr;
        blk_idx_t data;
    } link_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_LINK_PRED,
        ST_LINK_BLK,
        ST_LINK_HEAD
    } ilbr_state_t;

    // Link held by an entry right after reset: each block points at the next.
    function automatic blk_idx_t reset_link(input blk_idx_t idx);
        if (32'(idx) == NUM_BLOCKS - 1)
            reset_link = '0;
        else
            reset_link = idx + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ilbr_link_mem.sv =====
// Next-link table: synchronous memory with per-entry valid bits and write forwarding.
`default_nettype none

module ilbr_link_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ilbr_pkg::link_rd_t rd,
    input  wire ilbr_pkg::link_wr_t wr,
    output ilbr_pkg::blk_idx_t     rd_data
);
    import ilbr_pkg::*;

    blk_idx_t                mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   valid_reg;
    blk_idx_t                mem_q;
    blk_idx_t                addr_reg;
    blk_idx_t                fwd_data_reg;
    logic                    fwd_hit_reg;
    logic                    valid_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd.en)
        begin
            mem_q        <= mem[rd.addr];
            addr_reg     <= rd.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
            valid_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd.en)
            begin
                // A write to the entry being read in the same cycle wins.
                fwd_hit_reg   <= wr.en && (wr.addr == rd.addr);
                valid_hit_reg <= valid_reg[rd.addr];
            end
        end
    end

    // Entries never written still hold their reset link.
    always_comb
    begin
        if (fwd_hit_reg)
            rd_data = fwd_data_reg;
        else if (valid_hit_reg)
            rd_data = mem_q;
        else
            rd_data = reset_link(addr_reg);
    end

endmodule

`default_nettype wire

// ===== rtl/core/index_linked_block_ring_unit.sv =====
// Top level of the index-linked block ring: command sequencer around the link table.
`default_nettype none

// All blocks sit on one circular ring kept in a next-link memory, with head and
// tail pointers. A command is taken when start is high and busy is low, and its
// single result beat appears on rsp with done high for exactly one cycle; the
// receiver cannot stall it. An allocate reads the head link, then answers from
// ST_ALLOC through the done and rsp registers. A move walks the ring from the
// head, one link read per cycle on the single memory read port, and reads k
// links (1 to NUM_BLOCKS - 2) to find the predecessor; the relink then needs
// three writes on the single write port. A refused move (head, tail or out of
// range) answers in the cycle after it is taken and never raises busy.
module index_linked_block_ring_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ilbr_pkg::cmd_t cmd,
    output logic               busy,
    output logic               done,
    output ilbr_pkg::rsp_t     rsp
);
    import ilbr_pkg::*;

    ilbr_state_t state_reg, state_next;
    blk_idx_t    head_reg,  head_next;
    blk_idx_t    tail_reg,  tail_next;
    blk_idx_t    pred_reg,  pred_next;
    blk_idx_t    blk_reg,   blk_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsp_t        rsp_reg,   rsp_next;
    logic        done_reg,  done_next;

    link_rd_t    link_rd;
    link_wr_t    link_wr;
    blk_idx_t    link_q;
    blk_idx_t    cmd_idx;
    logic        cmd_refused;

    ilbr_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (link_rd),
        .wr      (link_wr),
        .rd_data (link_q)
    );

    assign cmd_idx     = cmd.block_number[IDX_W-1:0];
    assign cmd_refused = (32'(cmd.block_number) >= NUM_BLOCKS)
                         || (cmd_idx == head_reg) || (cmd_idx == tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= IDX_W'(NUM_BLOCKS - 1);
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pred_reg <= pred_next;
        blk_reg  <= blk_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        pred_next  = pred_reg;
        blk_next   = blk_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        link_rd    = '{en: 1'b0, addr: head_reg};
        link_wr    = '{en: 1'b0, addr: pred_reg, data: link_q};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    blk_next = cmd_idx;
                    if (cmd.mode == MODE_ALLOC)
                    begin
                        link_rd.en = 1'b1;
                        state_next = ST_ALLOC;
                    end
                    else if (cmd_refused)
                    begin
                        rsp_next  = '{result_block: 4'd0, status: STATUS_REFUSED};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        link_rd.en = 1'b1;
                        pred_next  = head_reg;
                        cnt_next   = '0;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_ALLOC:
            begin
                head_next  = link_q;
                tail_next  = head_reg;
                rsp_next   = '{result_block: 4'(head_reg), status: STATUS_DONE};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_WALK:
            begin
                // link_q is the successor of pred_reg.
                if (link_q == blk_reg)
                begin
                    link_rd    = '{en: 1'b1, addr: blk_reg};
                    state_next = ST_LINK_PRED;
                end
                else if (32'(cnt_reg) == NUM_BLOCKS - 1)
                begin
                    rsp_next   = '{result_block: 4'd0, status: STATUS_REFUSED};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    link_rd    = '{en: 1'b1, addr: link_q};
                    pred_next  = link_q;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end

            ST_LINK_PRED:
            begin
                // Unlink the block; the head read sees this write when pred is the head.
                link_wr    = '{en: 1'b1, addr: pred_reg, data: link_q};
                link_rd    = '{en: 1'b1, addr: head_reg};
                state_next = ST_LINK_BLK;
            end

            ST_LINK_BLK:
            begin
                link_wr    = '{en: 1'b1, addr: blk_reg, data: link_q};
                state_next = ST_LINK_HEAD;
            end

            ST_LINK_HEAD:
            begin
                link_wr    = '{en: 1'b1, addr: head_reg, data: blk_reg};
                rsp_next   = '{result_block: 4'(pred_reg), status: STATUS_DONE};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ===== tb/sv/ring_checker.sv =====
// Scoreboard for the block ring: tracks the ring, predicts every response beat and compares.
module ring_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  ilbr_pkg::cmd_t cmd,
    input  logic           done,
    input  ilbr_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ilbr_pkg::*;

    blk_idx_t ring_next [NUM_BLOCKS];
    blk_idx_t ring_head;
    blk_idx_t ring_tail;
    rsp_t     awaited_rsp_q [$];

    // Applies one command to the ring copy and returns the response it must produce.
    task automatic advance_ring(input cmd_t c, output rsp_t r);
        blk_idx_t pred;
        blk_idx_t blk;
        bit       found;
        int       step;
        r.result_block = '0;
        r.status       = STATUS_DONE;
        blk            = blk_idx_t'(c.block_number);
        if (c.mode == MODE_ALLOC)
        begin
            r.result_block = ring_head;
            ring_tail      = ring_head;
            ring_head      = ring_next[ring_head];
        end
        else if (int'(c.block_number) >= NUM_BLOCKS
                 || blk == ring_head || blk == ring_tail)
        begin
            r.status = STATUS_REFUSED;
        end
        else
        begin
            pred  = ring_head;
            found = 1'b0;
            for (step = 0; step < NUM_BLOCKS && !found; step++)
            begin
                if (ring_next[pred] == blk)
                    found = 1'b1;
                else
                    pred = ring_next[pred];
            end
            if (!found)
            begin
                r.status = STATUS_REFUSED;
            end
            else
            begin
                // When the block already follows the head these three writes leave
                // the ring as it was.
                ring_next[pred]      = ring_next[blk];
                ring_next[blk]       = ring_next[ring_head];
                ring_next[ring_head] = blk;
                r.result_block       = pred;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
                ring_next[i] = blk_idx_t'((i + 1) % NUM_BLOCKS);
            ring_head = '0;
            ring_tail = blk_idx_t'(NUM_BLOCKS - 1);
            awaited_rsp_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // The response checked here always belongs to an earlier command.
            if (done)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected response beat block=%0d stat=%0b",
                                 $realtime, rsp.result_block, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    if (rsp.result_block !== want.result_block
                        || rsp.status !== want.status)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: response mismatch block exp=%0d got=%0d",
                                      " stat exp=%0b got=%0b"},
                                     $realtime, want.result_block, rsp.result_block,
                                     want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                advance_ring(cmd, want);
                awaited_rsp_q.push_back(want);
            end
            pending_count = awaited_rsp_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the block ring: clock, reset, command stimulus, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ilbr_pkg::*;

    localparam int PHASE_ITEMS    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   sender_idle_pct = 0;
    int   quiet_cycles = 0;

    // Corner cases: head, tail, block already after the head, longest walks,
    // and both field extremes in each mode.
    cmd_t directed_cmds [$] = '{
        {MODE_ALLOC, 4'hF}, {MODE_MOVE, 4'd1},  {MODE_MOVE, 4'd0},  {MODE_MOVE, 4'd2},
        {MODE_MOVE, 4'd15}, {MODE_MOVE, 4'd14}, {MODE_ALLOC, 4'h0}, {MODE_MOVE, 4'd15},
        {MODE_MOVE, 4'd8},  {MODE_MOVE, 4'd13}, {MODE_ALLOC, 4'hA}, {MODE_ALLOC, 4'h5},
        {MODE_MOVE, 4'd0},  {MODE_MOVE, 4'd7},  {MODE_MOVE, 4'd3},  {MODE_ALLOC, 4'h0},
        {MODE_ALLOC, 4'hF}, {MODE_ALLOC, 4'h0}, {MODE_MOVE, 4'd15}, {MODE_MOVE, 4'd0},
        {MODE_MOVE, 4'd12}, {MODE_ALLOC, 4'h3}
    };

    always #5 clk = ~clk;

    index_linked_block_ring_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    ring_checker u_ring_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Ends the run when neither a command nor a response beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic issue_cmd(input cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_phase(input int idle_pct, input int count);
        cmd_t c;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            c.mode         = ($urandom_range(99) < 45) ? MODE_ALLOC : MODE_MOVE;
            c.block_number = 4'($urandom_range(15));
            issue_cmd(c);
        end
    endtask

    task automatic wait_all_responses();
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_cmds[i])
            issue_cmd(directed_cmds[i]);

        random_phase(38, PHASE_ITEMS);
        wait_all_responses();
        random_phase(46, PHASE_ITEMS);
        random_phase(0, PHASE_ITEMS);
        wait_all_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ilbr_pkg.sv
rtl/core/ilbr_link_mem.sv
rtl/core/index_linked_block_ring_unit.sv
tb/sv/ring_checker.sv
tb/sv/tb_top.sv
